// ----- src/ple_pkg.sv -----
package ple_pkg;

	localparam int POS_W        = 7;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;
	localparam int RADIX_LG     = 3;
	localparam int RADIX        = 1 << RADIX_LG;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_GET    = 2'd2,
		ACT_SET    = 2'd3
	} action_t;

	typedef struct packed {
		logic upd;
		logic ins;
		logic rem;
		logic wr;
		logic rd;
	} cell_cmd_t;

	function automatic int tree_nodes(int cap, int lvl);
		int n;
		n = cap;
		for (int k = 0; k < lvl; k++) begin
			n = (n + RADIX - 1) >> RADIX_LG;
		end
		return n;
	endfunction

	function automatic int tree_levels(int cap);
		int t;
		t = 1;
		while (tree_nodes(cap, t) > 1) begin
			t++;
		end
		return t;
	endfunction

	function automatic int tree_offset(int cap, int lvl);
		int s;
		s = 0;
		for (int m = 1; m < lvl; m++) begin
			s += tree_nodes(cap, m);
		end
		return s;
	endfunction

	function automatic int tree_total(int cap);
		return tree_offset(cap, tree_levels(cap) + 1);
	endfunction

endpackage

// ----- src/ple_req_if.sv -----
interface ple_req_if import ple_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [1:0]               action;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, action, position, value, input ready);
	modport sink (input valid, action, position, value, output ready);
endinterface

// ----- src/ple_rsp_if.sv -----
interface ple_rsp_if import ple_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic signed [DATA_W-1:0] read_value;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, ok, read_value, count, input ready);
	modport sink (input valid, ok, read_value, count, output ready);
endinterface

// ----- src/ple_cell.sv -----
module ple_cell import ple_pkg::*; #(
	parameter int CMP_W = 8,
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [CMP_W-1:0]  idx,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] hit
);

	localparam logic [CMP_W-1:0] HERE = CMP_W'(INDEX);

	logic [DATA_W-1:0] data_q;
	logic              at_w;
	logic              past_w;

	assign at_w   = (idx == HERE);
	assign past_w = (HERE > idx);

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			if (cmd.ins && past_w) begin
				data_q <= left;
			end else if ((cmd.ins || cmd.wr) && at_w) begin
				data_q <= value;
			end else if (cmd.rem && (at_w || past_w)) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;
	assign hit  = (cmd.rd && at_w) ? data_q : '0;

endmodule

// ----- src/positional_list_engine.sv -----
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// elements, addressed by 1-based position.
// req channel (valid/ready): action (insert, remove, get, set), position,
// value. rsp channel (valid/ready): ok, read_value, count.
// Each element lives in a cell of a row; insert moves every cell past the
// position one place up, remove moves the cells from the position on down.
// A get is answered through a registered OR tree of radix 8 over the cells,
// LEVELS = ceil(log8(CAPACITY)) deep (2 for 64 entries).
// One item is in flight at a time: a new req is taken only in idle, after
// the read tree has drained.
// rsp is held in an output register; a new req is taken while an earlier
// result still waits there. When the receiver stalls, the next result
// waits in its last step until the register frees up.
// Reset empties the list (count zero), returns to idle and clears the rsp
// valid flag; cell contents are not cleared, and entries past count are
// never read.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);

	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int LEVELS   = tree_levels(CAPACITY);
	localparam int TREE_TOT = tree_total(CAPACITY);
	localparam int DRN_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam logic [DRN_W-1:0] DRN_LAST = DRN_W'(LEVELS - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_APPLY = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t              state_q;
	logic [DRN_W-1:0]    drain_q;
	logic [CNT_W-1:0]    count_q;
	logic [1:0]          act_q;
	logic [POS_W-1:0]    pos_q;
	logic [DATA_W-1:0]   val_q;
	logic                ok_q;
	logic                rsp_valid_q;
	logic                rsp_ok_q;
	logic [DATA_W-1:0]   rsp_data_q;
	logic [COUNT_W-1:0]  rsp_cnt_q;

	logic [CMP_W-1:0]    pos_ext;
	logic [CMP_W-1:0]    cnt_ext;
	logic [CMP_W-1:0]    idx_w;
	logic                ok_c;
	logic                accept_w;
	logic                load_w;
	cell_cmd_t           cmd;

	wire [DATA_W-1:0]    data_w [CAPACITY];
	wire [DATA_W-1:0]    hit_w [CAPACITY];
	wire [DATA_W-1:0]    node_w [TREE_TOT];
	logic [DATA_W-1:0]   tree_q [TREE_TOT];

	assign pos_ext = CMP_W'(pos_q);
	assign cnt_ext = CMP_W'(count_q);
	assign idx_w   = pos_ext - CMP_W'(1);

	always_comb begin
		if (act_q == ACT_INSERT) begin
			ok_c = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
				&& (cnt_ext < CMP_W'(CAPACITY));
		end else begin
			ok_c = (pos_ext != '0) && (pos_ext <= cnt_ext);
		end
	end

	assign cmd.upd = (state_q == ST_APPLY) && ok_c && (act_q != ACT_GET);
	assign cmd.ins = (act_q == ACT_INSERT);
	assign cmd.rem = (act_q == ACT_REMOVE);
	assign cmd.wr  = (act_q == ACT_SET);
	assign cmd.rd  = ok_c && (act_q == ACT_GET);

	assign accept_w = req.valid && req.ready;
	assign load_w   = (state_q == ST_DRAIN) && (drain_q == DRN_LAST)
		&& (!rsp_valid_q || rsp.ready);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		wire [DATA_W-1:0] left_w;
		wire [DATA_W-1:0] right_w;

		if (i == 0) begin : g_head
			assign left_w = data_w[i];
		end else begin : g_body
			assign left_w = data_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = data_w[i];
		end else begin : g_next
			assign right_w = data_w[i+1];
		end

		ple_cell #(
			.CMP_W (CMP_W),
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (idx_w),
			.value (val_q),
			.left  (left_w),
			.right (right_w),
			.data  (data_w[i]),
			.hit   (hit_w[i])
		);
	end

	for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
		localparam int NIN    = tree_nodes(CAPACITY, k - 1);
		localparam int NOUT   = tree_nodes(CAPACITY, k);
		localparam int OFF    = tree_offset(CAPACITY, k);
		localparam int OFF_IN = tree_offset(CAPACITY, k - 1);

		for (genvar j = 0; j < NOUT; j++) begin : g_node
			wire [DATA_W-1:0] acc_w [RADIX];

			for (genvar c = 0; c < RADIX; c++) begin : g_kid
				if (j * RADIX + c >= NIN) begin : g_pad
					assign acc_w[c] = acc_w[c-1];
				end else begin : g_use
					wire [DATA_W-1:0] kid_w;

					if (k == 1) begin : g_leaf
						assign kid_w = hit_w[j*RADIX+c];
					end else begin : g_inner
						assign kid_w = tree_q[OFF_IN+j*RADIX+c];
					end

					if (c == 0) begin : g_first
						assign acc_w[c] = kid_w;
					end else begin : g_more
						assign acc_w[c] = acc_w[c-1] | kid_w;
					end
				end
			end

			assign node_w[OFF+j] = acc_w[RADIX-1];
		end
	end

	always_ff @(posedge clk) begin
		tree_q <= node_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drain_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.upd && cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.upd && cmd.rem) begin
				count_q <= count_q - CNT_W'(1);
			end

			if (load_w) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept_w) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_DRAIN;
					drain_q <= '0;
				end
				ST_DRAIN: begin
					if (load_w) begin
						state_q <= ST_IDLE;
					end else if (drain_q != DRN_LAST) begin
						drain_q <= drain_q + DRN_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_w) begin
			act_q <= req.action;
			pos_q <= req.position;
			val_q <= req.value;
		end
		if (state_q == ST_APPLY) begin
			ok_q <= ok_c;
		end
		if (load_w) begin
			rsp_ok_q   <= ok_q;
			rsp_data_q <= tree_q[TREE_TOT-1];
			rsp_cnt_q  <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.ok         = rsp_ok_q;
	assign rsp.read_value = rsp_data_q;
	assign rsp.count      = rsp_cnt_q;

endmodule

// ----- src/ple_chk.sv -----
module ple_chk import ple_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_ok,
	input logic [DATA_W-1:0] rsp_read_value
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req taken while an item is in flight");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("rsp appeared with no item in flight");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_read_value == '0)
		else $error("rejected item returned a nonzero value");

endmodule

bind positional_list_engine ple_chk u_ple_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.ok),
	.rsp_read_value (rsp.read_value)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import ple_pkg::*;

	localparam int DEPTH      = CAPACITY_DEF;
	localparam int IDLE_PCT   = 28;
	localparam int RANDOM_OPS = 1050;
	localparam int STALL_MAX  = 4000;
	localparam int DRAIN_CYC  = 16;
	localparam int STEADY_LO  = 400;
	localparam int STEADY_HI  = 600;

	typedef struct {
		action_t                  action;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} list_op_t;

	typedef struct {
		logic                     ok;
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]       count;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ple_req_if req_ch ();
	ple_rsp_if rsp_ch ();

	positional_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	list_op_t    op_backlog[$];
	list_reply_t reply_queue[$];

	logic signed [DATA_W-1:0] shadow_store[DEPTH];
	int shadow_len = 0;
	int plan_len = 0;

	bit req_took = 1'b0;
	int accepted_ops = 0;
	int replies_seen = 0;
	int errors = 0;
	int idle_cycles = 0;
	int act_tally[4] = '{0, 0, 0, 0};
	int ok_tally = 0;
	int full_rejects = 0;
	int peak_len = 0;

	function automatic list_reply_t apply_list_op(list_op_t op);
		list_reply_t r;
		int p;
		r.ok = 1'b0;
		r.read_value = '0;
		p = op.position;
		if (op.action == ACT_INSERT) begin
			if (p >= 1 && p <= shadow_len + 1 && shadow_len < DEPTH) begin
				for (int i = shadow_len; i > p - 1; i--)
					shadow_store[i] = shadow_store[i - 1];
				shadow_store[p - 1] = op.value;
				shadow_len++;
				r.ok = 1'b1;
			end
		end else if (p >= 1 && p <= shadow_len) begin
			r.ok = 1'b1;
			case (op.action)
				ACT_REMOVE: begin
					for (int i = p - 1; i + 1 < shadow_len; i++)
						shadow_store[i] = shadow_store[i + 1];
					shadow_len--;
				end
				ACT_GET: r.read_value = shadow_store[p - 1];
				default: shadow_store[p - 1] = op.value;
			endcase
		end
		r.count = COUNT_W'(shadow_len);
		return r;
	endfunction

	task automatic add_op(action_t a, int pos, logic signed [DATA_W-1:0] v);
		list_op_t op;
		op.action = a;
		op.position = POS_W'(pos);
		op.value = v;
		op_backlog.push_back(op);
		if (a == ACT_INSERT && pos >= 1 && pos <= plan_len + 1 && plan_len < DEPTH)
			plan_len++;
		else if (a == ACT_REMOVE && pos >= 1 && pos <= plan_len)
			plan_len--;
	endtask

	task automatic add_random_ops(int n);
		bit growing;
		int roll;
		int span;
		int pos;
		action_t a;
		logic signed [DATA_W-1:0] v;
		growing = 1'b1;
		for (int k = 0; k < n; k++) begin
			if (plan_len == DEPTH && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (plan_len == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 99) == 0)
				growing = !growing;
			roll = $urandom_range(0, 99);
			if (roll < (growing ? 45 : 15))
				a = ACT_INSERT;
			else if (roll < (growing ? 60 : 55))
				a = ACT_REMOVE;
			else if (roll < 80)
				a = ACT_GET;
			else
				a = ACT_SET;
			span = (a == ACT_INSERT) ? plan_len + 1 : plan_len;
			if ($urandom_range(0, 99) < 85)
				pos = (span > 0) ? $urandom_range(1, span) : 1;
			else begin
				case ($urandom_range(0, 2))
					0: pos = 0;
					1: pos = span + 1;
					default: pos = $urandom_range(span + 1, (1 << POS_W) - 1);
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = '0;
					default: v = -1;
				endcase
			end else
				v = $urandom;
			add_op(a, pos, v);
		end
	endtask

	always @(negedge clk) begin
		bit steady;
		list_op_t nxt;
		steady = accepted_ops >= STEADY_LO && accepted_ops < STEADY_HI;
		if (arst_n) begin
			if (!req_ch.valid || req_took) begin
				if (op_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = op_backlog.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.action <= nxt.action;
					req_ch.position <= nxt.position;
					req_ch.value <= nxt.value;
				end else
					req_ch.valid <= 1'b0;
			end
			rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		list_reply_t want;
		list_op_t op;
		bit rsp_took;
		req_took = arst_n && req_ch.valid && req_ch.ready;
		rsp_took = arst_n && rsp_ch.valid && rsp_ch.ready;
		if (rsp_took) begin
			replies_seen++;
			if (reply_queue.size() == 0) begin
				$error("unexpected reply: ok=%0b read_value=%0d count=%0d",
					rsp_ch.ok, rsp_ch.read_value, rsp_ch.count);
				errors++;
			end else begin
				want = reply_queue.pop_front();
				if (rsp_ch.ok !== want.ok) begin
					$error("ok: expected %0b, got %0b", want.ok, rsp_ch.ok);
					errors++;
				end
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d",
						want.read_value, rsp_ch.read_value);
					errors++;
				end
				if (rsp_ch.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, rsp_ch.count);
					errors++;
				end
			end
		end
		if (req_took) begin
			op.action = action_t'(req_ch.action);
			op.position = req_ch.position;
			op.value = req_ch.value;
			if (op.action == ACT_INSERT && shadow_len == DEPTH)
				full_rejects++;
			want = apply_list_op(op);
			reply_queue.push_back(want);
			accepted_ops++;
			act_tally[op.action]++;
			if (want.ok)
				ok_tally++;
			if (shadow_len > peak_len)
				peak_len = shadow_len;
		end
		if (!arst_n || req_took || rsp_took)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_MAX) begin
			$display("timeout after %0d cycles with no transfer", STALL_MAX);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.action = ACT_GET;
		req_ch.position = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;

		add_op(ACT_GET, 1, 0);
		add_op(ACT_REMOVE, 1, 0);
		add_op(ACT_SET, 1, 32'sh1111_2222);
		add_op(ACT_INSERT, 0, 5);
		add_op(ACT_INSERT, 2, 5);
		add_op(ACT_INSERT, 127, 5);
		add_op(ACT_INSERT, 1, 32'sh7fff_ffff);
		add_op(ACT_INSERT, 2, 32'sh8000_0000);
		add_op(ACT_INSERT, 1, 0);
		add_op(ACT_INSERT, 2, -1);
		for (int p = 1; p <= 4; p++)
			add_op(ACT_GET, p, 0);
		add_op(ACT_GET, 5, 0);
		add_op(ACT_GET, 0, 0);
		add_op(ACT_GET, 127, 0);
		add_op(ACT_SET, 3, 32'sh1234_5678);
		add_op(ACT_GET, 3, 0);
		add_op(ACT_SET, 5, 9);
		add_op(ACT_REMOVE, 2, 0);
		add_op(ACT_GET, 2, 32'sh5555_aaaa);
		add_op(ACT_REMOVE, 3, 0);
		add_op(ACT_REMOVE, 4, 0);
		add_op(ACT_REMOVE, 127, 0);
		add_random_ops(RANDOM_OPS);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (op_backlog.size() != 0 || reply_queue.size() != 0 ||
				(req_ch.valid && !req_took))
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);

		$display("%0d transfers checked: %0d insert, %0d remove, %0d get, %0d set, %0d ok",
			replies_seen, act_tally[ACT_INSERT], act_tally[ACT_REMOVE],
			act_tally[ACT_GET], act_tally[ACT_SET], ok_tally);
		$display("peak length %0d of %0d, %0d inserts rejected on a full list",
			peak_len, DEPTH, full_rejects);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/ple_pkg.sv
src/ple_req_if.sv
src/ple_rsp_if.sv
src/ple_cell.sv
src/positional_list_engine.sv
src/ple_chk.sv
bench/tb.sv
